// ===== src/urtb_pkg.sv =====
// Shared types and operation codes for the buffered serial-port front end.
package urtb_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned FLAGS_W = 3;
    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned COUNT_W = 16;

    localparam logic [FUNC_W-1:0] OP_RECEIVE  = 3'd0;
    localparam logic [FUNC_W-1:0] OP_READ     = 3'd1;
    localparam logic [FUNC_W-1:0] OP_WRITE    = 3'd2;
    localparam logic [FUNC_W-1:0] OP_TX_READY = 3'd3;
    localparam logic [FUNC_W-1:0] OP_FLUSH    = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BYTE_W-1:0]  line_byte;
        logic [FLAGS_W-1:0] line_error_flags;
        logic [BYTE_W-1:0]  host_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_byte;
        logic               read_valid;
        logic               write_refused;
        logic [BYTE_W-1:0]  line_out_byte;
        logic               line_out_valid;
        logic               transmit_request;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic [COUNT_W-1:0] error_total;
    } out_item_t;

    // One operation on a ring in one cycle; the top level never asks for
    // more than one of these at a time.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } ring_ctrl_t;

endpackage

// ===== src/uart_rx_tx_ring_buffers_core.sv =====
// Top level of the buffered serial-port front end: receive and transmit rings.
// An accepted transaction passes through stage one and then the output register before m_valid rises.
// Throughput: one transaction per cycle while results are taken; a stalled result
// lets one more transaction into stage one, then s_ready drops until it drains.
// Reset (aresetn, synchronous, active low) clears pointers, fill counts, the
// discard count and the transmit request; the ring RAMs are not cleared.
module uart_rx_tx_ring_buffers_core #(
    parameter int unsigned RX_DEPTH = 64,
    parameter int unsigned TX_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  urtb_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output urtb_pkg::out_item_t m_data
);

    localparam int unsigned RX_FILL_W = $clog2(RX_DEPTH + 1);
    localparam int unsigned TX_FILL_W = $clog2(TX_DEPTH + 1);
    localparam int unsigned LW        = urtb_pkg::LEVEL_W;

    // Handshake and pipeline control. Stage one holds a transaction whose
    // ring read is in flight; the output register holds a finished result.
    // The RAM read register only changes on a new pop, which only happens on
    // an accept, so read data stays put while stage one waits for the output.
    logic accept;
    logic out_free;
    logic s1_move;
    logic s1_valid_reg;

    assign out_free = !m_valid || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign s1_move  = s1_valid_reg && out_free;

    // Ring control and status.
    urtb_pkg::ring_ctrl_t rx_ctrl, tx_ctrl;
    logic [RX_FILL_W-1:0] rx_fill, rx_fill_next;
    logic [TX_FILL_W-1:0] tx_fill, tx_fill_next;
    logic [urtb_pkg::BYTE_W-1:0] rx_rd_data, tx_rd_data;

    logic rx_full;
    logic tx_full;
    logic rx_drop;

    assign rx_full = (rx_fill == RX_FILL_W'(RX_DEPTH));
    assign tx_full = (tx_fill == TX_FILL_W'(TX_DEPTH));

    // Persistent status registers.
    logic [urtb_pkg::COUNT_W-1:0] err_cnt_reg, err_cnt_next;
    logic                         irq_reg, irq_next;

    // Stage one registers.
    logic                 s1_read_valid_reg, s1_read_valid_next;
    logic                 s1_out_valid_reg, s1_out_valid_next;
    logic                 s1_refused_reg, s1_refused_next;
    logic [LW-1:0]        s1_rx_level_reg;
    logic [LW-1:0]        s1_tx_level_reg;
    logic [urtb_pkg::COUNT_W-1:0] s1_err_reg;
    logic                 s1_irq_reg;

    // Output register.
    logic                 m_valid_reg;
    urtb_pkg::out_item_t  m_data_reg;

    // Levels are reported in seven bits; wider fill counts are masked.
    logic [RX_FILL_W+LW-1:0] rx_level_wide;
    logic [TX_FILL_W+LW-1:0] tx_level_wide;

    assign rx_level_wide = {{LW{1'b0}}, rx_fill_next};
    assign tx_level_wide = {{LW{1'b0}}, tx_fill_next};

    // Decode the accepted transaction into ring operations and status updates.
    always_comb begin
        rx_ctrl            = '0;
        tx_ctrl            = '0;
        rx_drop            = 1'b0;
        irq_next           = irq_reg;
        s1_read_valid_next = 1'b0;
        s1_out_valid_next  = 1'b0;
        s1_refused_next    = 1'b0;
        if (accept) begin
            unique case (s_data.func)
                urtb_pkg::OP_RECEIVE: begin
                    if ((s_data.line_error_flags != '0) || rx_full) begin
                        rx_drop = 1'b1;
                    end else begin
                        rx_ctrl.push = 1'b1;
                    end
                end
                urtb_pkg::OP_READ: begin
                    if (rx_fill != '0) begin
                        rx_ctrl.pop        = 1'b1;
                        s1_read_valid_next = 1'b1;
                    end
                end
                urtb_pkg::OP_WRITE: begin
                    if (tx_full) begin
                        s1_refused_next = 1'b1;
                    end else begin
                        tx_ctrl.push = 1'b1;
                    end
                    irq_next = 1'b1;
                end
                urtb_pkg::OP_TX_READY: begin
                    if (tx_fill != '0) begin
                        tx_ctrl.pop       = 1'b1;
                        s1_out_valid_next = 1'b1;
                    end
                end
                urtb_pkg::OP_FLUSH: begin
                    rx_ctrl.clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
        // A ready tick that leaves the ring empty, or finds it empty, drops
        // the transmit request.
        if (accept && (s_data.func == urtb_pkg::OP_TX_READY) && (tx_fill_next == '0)) begin
            irq_next = 1'b0;
        end
        err_cnt_next = rx_drop ? err_cnt_reg + 1'b1 : err_cnt_reg;
    end

    urtb_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rx_ctrl),
        .wr_data   (s_data.line_byte),
        .fill      (rx_fill),
        .fill_next (rx_fill_next),
        .rd_data   (rx_rd_data)
    );

    urtb_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tx_ctrl),
        .wr_data   (s_data.host_byte),
        .fill      (tx_fill),
        .fill_next (tx_fill_next),
        .rd_data   (tx_rd_data)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_cnt_reg  <= '0;
            irq_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            err_cnt_reg <= err_cnt_next;
            irq_reg     <= irq_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the status after the step is captured at accept,
    // ring read data is merged when the transaction leaves stage one.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_read_valid_reg <= s1_read_valid_next;
            s1_out_valid_reg  <= s1_out_valid_next;
            s1_refused_reg    <= s1_refused_next;
            s1_rx_level_reg   <= rx_level_wide[LW-1:0];
            s1_tx_level_reg   <= tx_level_wide[LW-1:0];
            s1_err_reg        <= err_cnt_next;
            s1_irq_reg        <= irq_next;
        end
        if (s1_move) begin
            m_data_reg.read_byte        <= s1_read_valid_reg ? rx_rd_data : '0;
            m_data_reg.read_valid       <= s1_read_valid_reg;
            m_data_reg.write_refused    <= s1_refused_reg;
            m_data_reg.line_out_byte    <= s1_out_valid_reg ? tx_rd_data : '0;
            m_data_reg.line_out_valid   <= s1_out_valid_reg;
            m_data_reg.transmit_request <= s1_irq_reg;
            m_data_reg.rx_level         <= s1_rx_level_reg;
            m_data_reg.tx_level         <= s1_tx_level_reg;
            m_data_reg.error_total      <= s1_err_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // A transaction is either a read or a ready tick, never both.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.read_valid && m_data.line_out_valid))
        else $error("read and transmit hand-out reported in one result");

    // A refused write still raises the transmit request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.write_refused) |-> m_data.transmit_request)
        else $error("refused write without transmit request");

    // Fill counts never pass the ring depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_fill <= RX_FILL_W'(RX_DEPTH)) && (tx_fill <= TX_FILL_W'(TX_DEPTH)))
        else $error("ring fill count beyond depth");

    // Stage one always drains when the output side is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_free && !accept) |=> (!s1_valid_reg && m_valid))
        else $error("stage one did not move to the output register");
`endif

endmodule

// ===== src/urtb_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module urtb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/urtb_ring.sv =====
// Ring buffer: read and write pointers, fill count and the backing RAM.
module urtb_ring #(
    parameter int unsigned DEPTH = 64,
    localparam int unsigned PTR_W  = $clog2(DEPTH),
    localparam int unsigned FILL_W = $clog2(DEPTH + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  urtb_pkg::ring_ctrl_t       ctrl,
    input  logic [urtb_pkg::BYTE_W-1:0] wr_data,
    output logic [FILL_W-1:0]          fill,
    output logic [FILL_W-1:0]          fill_next,
    output logic [urtb_pkg::BYTE_W-1:0] rd_data
);

    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0] fill_reg;

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (ctrl.clear) begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
        end else if (ctrl.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end else if (ctrl.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    assign fill = fill_reg;

    urtb_ram #(
        .WIDTH (urtb_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ctrl.push && !ctrl.clear),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_data),
        .rd_en   (ctrl.pop && !ctrl.clear),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the buffered serial-port front end (receive and transmit rings).
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned RX_DEPTH     = 64;
    localparam int unsigned TX_DEPTH     = 64;
    localparam int unsigned RANDOM_ITEMS = 650;
    localparam int unsigned MAX_WAIT     = 11;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    // Function codes that select no operation.
    localparam logic [urtb_pkg::FUNC_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [urtb_pkg::FUNC_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [urtb_pkg::FUNC_W-1:0] OP_SPARE_C = 3'd7;

    // A row of the directed table. When pinned is set, the status is the
    // value typed into the table and replaces the prediction for that row.
    typedef struct {
        urtb_pkg::in_item_t  stim;
        bit                  pinned;
        urtb_pkg::out_item_t status;
    } plan_row_t;

    typedef struct {
        bit                  pinned;
        urtb_pkg::out_item_t status;
    } pin_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    urtb_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    urtb_pkg::out_item_t m_data;

    uart_rx_tx_ring_buffers_core #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of both rings, their pointers and fill
    // counts, the discard count and the transmit request flag.
    // ------------------------------------------------------------------
    logic [urtb_pkg::BYTE_W-1:0]  rx_ring [RX_DEPTH];
    logic [urtb_pkg::BYTE_W-1:0]  tx_ring [TX_DEPTH];
    int unsigned                  rx_head, rx_tail, rx_count;
    int unsigned                  tx_head, tx_tail, tx_count;
    logic [urtb_pkg::COUNT_W-1:0] drop_count;
    logic                         tx_request;

    urtb_pkg::out_item_t expected_status_q [$];
    pin_t                pinned_q [$];
    plan_row_t           plan [$];
    int unsigned         error_count;
    int unsigned         cycle_count;
    int unsigned         random_sent;
    bit                  calm;

    // Applies one accepted transaction to the predictor state and returns
    // the status the block must report for it.
    function automatic urtb_pkg::out_item_t serial_front_step(input urtb_pkg::in_item_t item);
        urtb_pkg::out_item_t st;
        st = '0;
        case (item.func)
            urtb_pkg::OP_RECEIVE: begin
                // Any line error, or no room left, drops the byte and counts it.
                if (item.line_error_flags != '0 || rx_count >= RX_DEPTH) begin
                    drop_count = drop_count + 1'b1;
                end else begin
                    rx_ring[rx_tail] = item.line_byte;
                    rx_tail  = (rx_tail + 1 >= RX_DEPTH) ? 0 : rx_tail + 1;
                    rx_count = rx_count + 1;
                end
            end
            urtb_pkg::OP_READ: begin
                if (rx_count != 0) begin
                    st.read_byte  = rx_ring[rx_head];
                    st.read_valid = 1'b1;
                    rx_head  = (rx_head + 1 >= RX_DEPTH) ? 0 : rx_head + 1;
                    rx_count = rx_count - 1;
                end
            end
            urtb_pkg::OP_WRITE: begin
                if (tx_count >= TX_DEPTH) begin
                    st.write_refused = 1'b1;
                end else begin
                    tx_ring[tx_tail] = item.host_byte;
                    tx_tail  = (tx_tail + 1 >= TX_DEPTH) ? 0 : tx_tail + 1;
                    tx_count = tx_count + 1;
                end
                // The request goes up on every write, refused or not.
                tx_request = 1'b1;
            end
            urtb_pkg::OP_TX_READY: begin
                if (tx_count != 0) begin
                    st.line_out_byte  = tx_ring[tx_head];
                    st.line_out_valid = 1'b1;
                    tx_head  = (tx_head + 1 >= TX_DEPTH) ? 0 : tx_head + 1;
                    tx_count = tx_count - 1;
                end
                if (tx_count == 0) begin
                    tx_request = 1'b0;
                end
            end
            urtb_pkg::OP_FLUSH: begin
                rx_count = 0;
                rx_head  = 0;
                rx_tail  = 0;
            end
            default: begin
                // Unused codes only report the status.
            end
        endcase
        st.transmit_request = tx_request;
        st.rx_level         = urtb_pkg::LEVEL_W'(rx_count);
        st.tx_level         = urtb_pkg::LEVEL_W'(tx_count);
        st.error_total      = drop_count;
        return st;
    endfunction

    // Status of an operation that moved no data: only the discard count shows.
    function automatic urtb_pkg::out_item_t quiet_status(input int unsigned drops);
        urtb_pkg::out_item_t st;
        st = '0;
        st.error_total = urtb_pkg::COUNT_W'(drops);
        return st;
    endfunction

    function automatic urtb_pkg::in_item_t make_item(
        input logic [urtb_pkg::FUNC_W-1:0]  f,
        input logic [urtb_pkg::BYTE_W-1:0]  lb,
        input logic [urtb_pkg::FLAGS_W-1:0] fl,
        input logic [urtb_pkg::BYTE_W-1:0]  hb);
        urtb_pkg::in_item_t item;
        item.func             = f;
        item.line_byte        = lb;
        item.line_error_flags = fl;
        item.host_byte        = hb;
        return item;
    endfunction

    task automatic add_row(input urtb_pkg::in_item_t stim, input bit pinned,
                           input urtb_pkg::out_item_t status);
        plan_row_t row;
        row.stim   = stim;
        row.pinned = pinned;
        row.status = status;
        plan.push_back(row);
    endtask

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic check_status(input urtb_pkg::out_item_t want,
                                input urtb_pkg::out_item_t got);
        if (got.read_byte !== want.read_byte) begin
            $error("read_byte: expected %0h, got %0h", want.read_byte, got.read_byte);
            error_count++;
        end
        if (got.read_valid !== want.read_valid) begin
            $error("read_valid: expected %0b, got %0b", want.read_valid, got.read_valid);
            error_count++;
        end
        if (got.write_refused !== want.write_refused) begin
            $error("write_refused: expected %0b, got %0b",
                   want.write_refused, got.write_refused);
            error_count++;
        end
        if (got.line_out_byte !== want.line_out_byte) begin
            $error("line_out_byte: expected %0h, got %0h",
                   want.line_out_byte, got.line_out_byte);
            error_count++;
        end
        if (got.line_out_valid !== want.line_out_valid) begin
            $error("line_out_valid: expected %0b, got %0b",
                   want.line_out_valid, got.line_out_valid);
            error_count++;
        end
        if (got.transmit_request !== want.transmit_request) begin
            $error("transmit_request: expected %0b, got %0b",
                   want.transmit_request, got.transmit_request);
            error_count++;
        end
        if (got.rx_level !== want.rx_level) begin
            $error("rx_level: expected %0d, got %0d", want.rx_level, got.rx_level);
            error_count++;
        end
        if (got.tx_level !== want.tx_level) begin
            $error("tx_level: expected %0d, got %0d", want.tx_level, got.tx_level);
            error_count++;
        end
        if (got.error_total !== want.error_total) begin
            $error("error_total: expected %0d, got %0d", want.error_total, got.error_total);
            error_count++;
        end
    endtask

    // Drives one transaction on the input channel and returns at the edge
    // where it is accepted. A gap of zero keeps valid high straight into the
    // next transaction, so valid is never dropped and raised in one step.
    task automatic send_item(input urtb_pkg::in_item_t stim, input bit pinned,
                             input urtb_pkg::out_item_t status);
        int unsigned gap;
        pin_t        pin;
        gap = draw_wait();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pin.pinned = pinned;
        pin.status = status;
        pinned_q.push_back(pin);
        s_valid <= 1'b1;
        s_data  <= stim;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Random content under a chosen operation. Received bytes mostly arrive
    // clean so that the receive ring actually fills.
    task automatic send_random(input logic [urtb_pkg::FUNC_W-1:0] f);
        urtb_pkg::in_item_t stim;
        stim = make_item(f, urtb_pkg::BYTE_W'($urandom), '0, urtb_pkg::BYTE_W'($urandom));
        if (f == urtb_pkg::OP_RECEIVE && $urandom_range(0, 9) == 0) begin
            stim.line_error_flags = urtb_pkg::FLAGS_W'($urandom_range(1, 7));
        end
        send_item(stim, 1'b0, '0);
        random_sent++;
    endtask

    task automatic send_noise();
        urtb_pkg::in_item_t stim;
        stim = make_item(urtb_pkg::FUNC_W'($urandom), urtb_pkg::BYTE_W'($urandom),
                         urtb_pkg::FLAGS_W'($urandom), urtb_pkg::BYTE_W'($urandom));
        send_item(stim, 1'b0, '0);
        random_sent++;
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_status_q.size() != 0 || pinned_q.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Scoreboard. Each accepted input transaction is run through the
    // predictor at the edge that accepts it; each accepted result
    // transaction is compared with the oldest expectation. The push comes
    // first so that ordering within the edge does not matter.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        pin_t                pin;
        urtb_pkg::out_item_t predicted;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pin       = pinned_q.pop_front();
                predicted = serial_front_step(s_data);
                expected_status_q.push_back(pin.pinned ? pin.status : predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_status_q.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    error_count++;
                end else begin
                    check_status(expected_status_q.pop_front(), m_data);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Result side: a fresh stall is drawn for every result transaction, and
    // ready then stays high until one is taken.
    initial begin : result_sink
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic [urtb_pkg::FUNC_W-1:0] mix [4];
        int unsigned                 n;

        mix         = '{urtb_pkg::OP_RECEIVE, urtb_pkg::OP_READ,
                        urtb_pkg::OP_WRITE, urtb_pkg::OP_TX_READY};
        error_count = 0;
        cycle_count = 0;
        random_sent = 0;
        calm        = 1'b0;

        rx_head    = 0;
        rx_tail    = 0;
        rx_count   = 0;
        tx_head    = 0;
        tx_tail    = 0;
        tx_count   = 0;
        drop_count = '0;
        tx_request = 1'b0;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table. Rows whose status is obvious after reset, or which
        // only bump the discard count, carry it typed in; the rest go through
        // the predictor.
        add_row(make_item(urtb_pkg::OP_READ,     8'h00, 3'b000, 8'h00), 1'b1, quiet_status(0));
        add_row(make_item(urtb_pkg::OP_TX_READY, 8'h00, 3'b000, 8'h00), 1'b1, quiet_status(0));
        add_row(make_item(OP_SPARE_A,            8'hFF, 3'b111, 8'hFF), 1'b1, quiet_status(0));
        add_row(make_item(OP_SPARE_B,            8'h5A, 3'b010, 8'hA5), 1'b1, quiet_status(0));
        add_row(make_item(OP_SPARE_C,            8'hFF, 3'b111, 8'hFF), 1'b1, quiet_status(0));
        add_row(make_item(urtb_pkg::OP_FLUSH,    8'hFF, 3'b111, 8'hFF), 1'b1, quiet_status(0));
        // Each line error on its own, then all of them, drops the byte.
        add_row(make_item(urtb_pkg::OP_RECEIVE,  8'hFF, 3'b001, 8'h00), 1'b1, quiet_status(1));
        add_row(make_item(urtb_pkg::OP_RECEIVE,  8'h00, 3'b010, 8'h00), 1'b1, quiet_status(2));
        add_row(make_item(urtb_pkg::OP_RECEIVE,  8'h55, 3'b100, 8'h00), 1'b1, quiet_status(3));
        add_row(make_item(urtb_pkg::OP_RECEIVE,  8'hFF, 3'b111, 8'hFF), 1'b1, quiet_status(4));
        add_row(make_item(urtb_pkg::OP_RECEIVE,  8'h00, 3'b000, 8'hFF), 1'b0, '0);
        add_row(make_item(urtb_pkg::OP_RECEIVE,  8'hFF, 3'b000, 8'h00), 1'b0, '0);
        add_row(make_item(urtb_pkg::OP_RECEIVE,  8'h1C, 3'b000, 8'h00), 1'b0, '0);
        add_row(make_item(urtb_pkg::OP_READ,     8'hFF, 3'b111, 8'hFF), 1'b0, '0);
        add_row(make_item(urtb_pkg::OP_READ,     8'h00, 3'b000, 8'h00), 1'b0, '0);
        // Flush drops the byte still held; a read afterwards finds nothing.
        add_row(make_item(urtb_pkg::OP_FLUSH,    8'h00, 3'b000, 8'h00), 1'b0, '0);
        add_row(make_item(urtb_pkg::OP_READ,     8'h00, 3'b000, 8'h00), 1'b1, quiet_status(4));
        add_row(make_item(urtb_pkg::OP_WRITE,    8'hFF, 3'b111, 8'h00), 1'b0, '0);
        add_row(make_item(urtb_pkg::OP_WRITE,    8'h00, 3'b000, 8'hFF), 1'b0, '0);
        add_row(make_item(urtb_pkg::OP_TX_READY, 8'hFF, 3'b111, 8'hFF), 1'b0, '0);
        // This tick empties the transmit ring and must clear the request.
        add_row(make_item(urtb_pkg::OP_TX_READY, 8'h00, 3'b000, 8'h00), 1'b0, '0);
        add_row(make_item(urtb_pkg::OP_TX_READY, 8'h00, 3'b000, 8'h00), 1'b1, quiet_status(4));
        add_row(make_item(urtb_pkg::OP_WRITE,    8'h00, 3'b000, 8'h3C), 1'b0, '0);

        foreach (plan[i]) begin
            send_item(plan[i].stim, plan[i].pinned, plan[i].status);
        end

        // Let the directed part settle completely before the random part.
        wait_for_idle();

        // Random part: mostly bursts that fill and drain the rings (some
        // long enough to overflow them), mixed traffic, flushes and noise.
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 8)) send_noise();
                end
                2: begin
                    n = ($urandom_range(0, 2) == 0) ? 70 : $urandom_range(1, 40);
                    repeat (n) send_random(urtb_pkg::OP_RECEIVE);
                end
                3: begin
                    n = ($urandom_range(0, 2) == 0) ? 70 : $urandom_range(1, 40);
                    repeat (n) send_random(urtb_pkg::OP_READ);
                end
                4: begin
                    n = ($urandom_range(0, 2) == 0) ? 70 : $urandom_range(1, 40);
                    repeat (n) send_random(urtb_pkg::OP_WRITE);
                end
                5: begin
                    n = ($urandom_range(0, 2) == 0) ? 70 : $urandom_range(1, 40);
                    repeat (n) send_random(urtb_pkg::OP_TX_READY);
                end
                6: begin
                    repeat ($urandom_range(4, 30)) send_random(mix[$urandom_range(0, 3)]);
                end
                7: begin
                    repeat ($urandom_range(0, 6)) send_random(urtb_pkg::OP_RECEIVE);
                    send_random(urtb_pkg::OP_FLUSH);
                end
                8: begin
                    wait_for_idle();
                    send_noise();
                end
                default: begin
                    // Switch between back-to-back traffic and random idling.
                    calm = !calm;
                end
            endcase
        end

        s_valid <= 1'b0;
        while (expected_status_q.size() != 0 || pinned_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
